>>> rtl/isqrt_pkg.sv
// Shared width helpers for the integer square root block.
package isqrt_pkg;

    // Width of the floor root of a value of the given width.
    function automatic int calc_root_width(input int in_width);
        return (in_width + 1) >> 1;
    endfunction

    // Width of a field padded up to whole bytes.
    function automatic int calc_byte_width(input int width);
        return ((width + 7) >> 3) << 3;
    endfunction

endpackage

>>> rtl/isqrt_cell.sv
// One cell of the square root chain: settles one root bit per transaction.
module isqrt_cell #(
    parameter int W2      = 32,
    parameter int BIT_POS = 30
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [W2-1:0] in_rem,
    input  logic [W2-1:0] in_acc,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [W2-1:0] out_rem,
    output logic [W2-1:0] out_acc
);
    import isqrt_pkg::*;

    localparam logic [W2-1:0] BIT = {{(W2-1){1'b0}}, 1'b1} << BIT_POS;

    logic          valid_reg;
    logic          valid_next;
    logic [W2-1:0] rem_reg;
    logic [W2-1:0] rem_next;
    logic [W2-1:0] acc_reg;
    logic [W2-1:0] acc_next;
    logic [W2:0]   trial;
    logic          load;

    // A cell takes new data when empty or when its neighbor drains it.
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        trial = {1'b0, in_acc} + {1'b0, BIT};
        if ({1'b0, in_rem} >= trial)
        begin
            rem_next = in_rem - trial[W2-1:0];
            acc_next = (in_acc >> 1) | BIT;
        end
        else
        begin
            rem_next = in_rem;
            acc_next = in_acc >> 1;
        end
        if (in_ready)
            valid_next = in_valid;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_acc   = acc_reg;

endmodule

>>> rtl/integer_square_root_top.sv
// Top level of the integer square root: a chain of one cell per root bit.
//
//  channel   direction  tdata contents                         tlast/tuser
//  s_*       in         radicand, IN_WIDTH bits, byte padded   none
//  m_*       out        root, ceil(IN_WIDTH/2) bits, padded    none
//
// Each radicand passes through ceil(IN_WIDTH/2) cells, each of which registers
// its remainder and root accumulator before handing them to the next cell.
// The chain takes a new radicand every cycle while results drain.
// Reset clears the valid bit of every cell; data registers are not reset.
// A stall on m_tready backs up cell by cell; empty cells keep filling.
module integer_square_root_top #(
    parameter int IN_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // [IN_WIDTH-1:0] radicand, upper bits padding
    input  logic [isqrt_pkg::calc_byte_width(IN_WIDTH)-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // [ROOT_WIDTH-1:0] root, upper bits zero
    output logic [isqrt_pkg::calc_byte_width(isqrt_pkg::calc_root_width(IN_WIDTH))-1:0]
        m_tdata
);
    import isqrt_pkg::*;

    localparam int RW     = calc_root_width(IN_WIDTH);
    localparam int W2     = 2 * RW;
    localparam int OUT_BW = calc_byte_width(RW);

    logic [W2-1:0] rem_w   [0:RW];
    logic [W2-1:0] acc_w   [0:RW];
    logic          valid_w [0:RW];
    logic          ready_w [0:RW];

    assign rem_w[0]   = {{(W2-IN_WIDTH){1'b0}}, s_tdata[IN_WIDTH-1:0]};
    assign acc_w[0]   = '0;
    assign valid_w[0] = s_tvalid;
    assign s_tready   = ready_w[0];

    for (genvar i = 0; i < RW; i++)
    begin : g_cell
        isqrt_cell #(
            .W2      (W2),
            .BIT_POS (W2 - 2 - 2 * i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_w[i]),
            .in_ready  (ready_w[i]),
            .in_rem    (rem_w[i]),
            .in_acc    (acc_w[i]),
            .out_valid (valid_w[i+1]),
            .out_ready (ready_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_acc   (acc_w[i+1])
        );
    end

    assign ready_w[RW] = m_tready;
    assign m_tvalid    = valid_w[RW];

    // After the last cell the root sits in the low bits of the accumulator.
    if (OUT_BW > RW)
    begin : g_pad
        assign m_tdata = {{(OUT_BW-RW){1'b0}}, acc_w[RW][RW-1:0]};
    end
    else
    begin : g_nopad
        assign m_tdata = acc_w[RW][RW-1:0];
    end

endmodule

>>> rtl/isqrt_chk.sv
// Port-level checker for the integer square root, bound to the top level.
module isqrt_chk #(
    parameter int IN_WIDTH = 32
) (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic [isqrt_pkg::calc_byte_width(IN_WIDTH)-1:0] s_tdata,
    input logic m_tvalid,
    input logic m_tready,
    input logic [isqrt_pkg::calc_byte_width(isqrt_pkg::calc_root_width(IN_WIDTH))-1:0]
        m_tdata
);
    import isqrt_pkg::*;

    // A stalled result keeps its value until the transaction completes.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The input side can only be blocked while a result is held stalled at the output.
    a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input blocked with room in the chain");

    // No result is shown during reset or in the cycle it is released.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n || $rose(rst_n) |-> !m_tvalid)
        else $error("result valid out of reset");

    // The chain, empty out of reset, does not block the input side as reset is released.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> s_tready)
        else $error("input blocked out of reset");

endmodule

bind integer_square_root_top isqrt_chk #(
    .IN_WIDTH (IN_WIDTH)
) u_isqrt_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
